[rtl/core/positional_list_insert_delete_search_macros.svh]
// ----------------------------------------------------------------------------
// Positional list assertion macros
// Concurrent check wrappers shared by the list RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_SEARCH_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_SEARCH_MACROS_SVH

// condition holds at every edge out of reset
`define PLIL_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("positional list check failed");

// antecedent at one edge implies consequent at the next
`define PLIL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional list sequence check failed");

`endif

[rtl/core/plil_pkg.sv]
// ----------------------------------------------------------------------------
// Positional list package
// Sizes, codes and command types shared by the list cells, tree and top.
// ----------------------------------------------------------------------------
package plil_pkg;

   localparam int CAPACITY = 128;

   localparam int VAL_W    = 32;
   localparam int OP_W     = 3;
   localparam int POS_W    = 8;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 7;
   localparam int ECNT_W   = 8;

   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int LEVELS   = IDX_W;
   localparam int LEAVES   = 1 << LEVELS;
   localparam int WAIT_W   = $clog2(LEVELS + 1);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 3'd0,
      OP_APPEND = 3'd1,
      OP_READ   = 3'd2,
      OP_INSERT = 3'd3,
      OP_DELETE = 3'd4,
      OP_SEARCH = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD_POS = 2'd2,
      ST_NO_KEY  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_WRITE,
      ACT_INSERT,
      ACT_DELETE
   } action_type;

   typedef enum logic [1:0] {
      PRB_NONE,
      PRB_SELECT,
      PRB_MATCH
   } probe_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_TREE,
      S_EMIT
   } state_type;

   typedef struct packed {
      action_type               action;
      probe_type                probe;
      logic [CMP_W-1:0]         pos;
      logic [CMP_W-1:0]         count;
      logic signed [VAL_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic                     hit;
      logic [IDX_W-1:0]         index;
      logic signed [VAL_W-1:0]  data;
   } node_type;

endpackage

[rtl/core/plil_if.sv]
// ----------------------------------------------------------------------------
// Positional list channels
// Valid/ready request and response channels of the list.
// ----------------------------------------------------------------------------
interface plil_req_if;
   import plil_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic [POS_W-1:0]         position;
   logic signed [VAL_W-1:0]  value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface plil_rsp_if;
   import plil_pkg::*;

   logic                     valid;
   logic                     ready;
   status_type               status;
   logic signed [VAL_W-1:0]  read_value;
   logic [FOUND_W-1:0]       found_index;
   logic [ECNT_W-1:0]        entry_count;

   modport source (output valid, output status, output read_value, output found_index,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input read_value, input found_index,
                   input entry_count, output ready);
endinterface

[rtl/core/plil_cell.sv]
// ----------------------------------------------------------------------------
// Positional list cell
// One list entry: writes, shifts with its neighbors and flags a probe hit.
// ----------------------------------------------------------------------------
module plil_cell (
   input  logic                              clock,
   input  plil_pkg::cmd_type                 cmd,
   input  logic [plil_pkg::CMP_W-1:0]        index,
   input  logic signed [plil_pkg::VAL_W-1:0] left_data,
   input  logic signed [plil_pkg::VAL_W-1:0] right_data,
   output logic signed [plil_pkg::VAL_W-1:0] data,
   output logic                              hit
);
   import plil_pkg::*;

   logic signed [VAL_W-1:0] data_ff, data_in;
   logic                    hit_ff, hit_in;
   logic                    in_use;

   assign in_use = index < cmd.count;

   always_comb begin
      data_in = data_ff;
      case (cmd.action)
         ACT_WRITE: begin
            if (index == cmd.pos) data_in = cmd.value;
         end
         ACT_INSERT: begin
            if (index == cmd.pos) data_in = cmd.value;
            else if (index > cmd.pos) data_in = left_data;
         end
         ACT_DELETE: begin
            if (index >= cmd.pos) data_in = right_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_comb begin
      hit_in = hit_ff;
      case (cmd.probe)
         PRB_SELECT: hit_in = in_use && (index == cmd.pos);
         PRB_MATCH:  hit_in = in_use && (data_ff == cmd.value);
         default:    hit_in = hit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

[rtl/core/plil_tree.sv]
// ----------------------------------------------------------------------------
// Positional list hit tree
// Registered tree that picks the lowest flagged cell and its entry.
// ----------------------------------------------------------------------------
module plil_tree (
   input  logic                              clock,
   input  logic [plil_pkg::CAPACITY-1:0]     leaf_hit,
   input  logic signed [plil_pkg::VAL_W-1:0] leaf_data [plil_pkg::CAPACITY],
   output plil_pkg::node_type                root
);
   import plil_pkg::*;

   node_type leaf    [LEAVES];
   node_type node_ff [LEAVES-1];

   for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < CAPACITY) begin : g_used
         assign leaf[j] = '{hit: leaf_hit[j], index: IDX_W'(j), data: leaf_data[j]};
      end else begin : g_pad
         assign leaf[j] = '{hit: 1'b0, index: IDX_W'(j), data: '0};
      end
   end

   for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
      node_type lo, hi;
      if (2 * k + 1 >= LEAVES - 1) begin : g_lo_leaf
         assign lo = leaf[2 * k + 1 - (LEAVES - 1)];
      end else begin : g_lo_node
         assign lo = node_ff[2 * k + 1];
      end
      if (2 * k + 2 >= LEAVES - 1) begin : g_hi_leaf
         assign hi = leaf[2 * k + 2 - (LEAVES - 1)];
      end else begin : g_hi_node
         assign hi = node_ff[2 * k + 2];
      end
      always_ff @(posedge clock) begin
         node_ff[k] <= lo.hit ? lo : hi;
      end
   end

   assign root = node_ff[0];

endmodule

[rtl/core/positional_list_insert_delete_search.sv]
// ----------------------------------------------------------------------------
// Positional list with insert, delete, read and search
// Ordered list of signed entries held in a shifting row of cells.
// ----------------------------------------------------------------------------
// channel   dir  handshake    payload
// req_chan  in   valid/ready  op, position, value
// rsp_chan  out  valid/ready  status, read_value, found_index, entry_count
//
// Clear, append, insert, delete, unused codes and refused items pass through
// accept, cell update and response load; an in-range read and any search also
// pass the registered hit tree. Response load waits for an untaken response.
// One item is in work at a time; a new item is taken while a response waits.
// Synchronous reset empties the list; entries stay unknown until written.
// ----------------------------------------------------------------------------
`include "positional_list_insert_delete_search_macros.svh"

module positional_list_insert_delete_search (
   input logic         clock,
   input logic         reset,
   plil_req_if.sink    req_chan,
   plil_rsp_if.source  rsp_chan
);
   import plil_pkg::*;

   state_type               state_ff, state_in;
   op_type                  op_ff;
   logic [POS_W-1:0]        pos_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   status_type              status_ff, status_in;
   logic [WAIT_W-1:0]       wait_ff, wait_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic signed [VAL_W-1:0] rsp_read_ff, rsp_read_in;
   logic [FOUND_W-1:0]      rsp_found_ff, rsp_found_in;
   logic [ECNT_W-1:0]       rsp_count_ff, rsp_count_in;

   cmd_type                 cmd;
   logic                    tree_go;
   logic                    rsp_load;
   logic                    accept;
   logic                    full;
   logic                    cells_idle;
   logic [CMP_W-1:0]        pos_w, cnt_w;

   logic signed [VAL_W-1:0] cell_data [CAPACITY];
   logic [CAPACITY-1:0]     cell_hit;
   node_type                root;

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_data, right_data;
      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end
      plil_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .index      (CMP_W'(i)),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .hit        (cell_hit[i])
      );
   end

   plil_tree u_tree (
      .clock     (clock),
      .leaf_hit  (cell_hit),
      .leaf_data (cell_data),
      .root      (root)
   );

   assign accept = req_chan.valid && req_chan.ready;
   assign pos_w  = CMP_W'(pos_ff);
   assign cnt_w  = CMP_W'(count_ff);
   assign full   = count_ff >= CNT_W'(CAPACITY);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_EXEC;
         S_EXEC: state_in = tree_go ? S_TREE : S_EMIT;
         S_TREE: if (wait_ff == '0) state_in = S_EMIT;
         S_EMIT: if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = 1'b0;
      cmd            = '{action: ACT_HOLD, probe: PRB_NONE, pos: pos_w, count: cnt_w,
                         value: val_ff};
      tree_go        = 1'b0;
      count_in       = count_ff;
      status_in      = status_ff;
      wait_in        = wait_ff;
      rsp_load       = 1'b0;
      rsp_status_in  = status_ff;
      rsp_read_in    = '0;
      rsp_found_in   = '0;
      rsp_count_in   = ECNT_W'(count_ff);
      unique case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
         end
         S_EXEC: begin
            status_in = ST_OK;
            wait_in   = WAIT_W'(LEVELS - 1);
            case (op_ff)
               OP_CLEAR: begin
                  count_in = '0;
               end
               OP_APPEND: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.action = ACT_WRITE;
                     cmd.pos    = cnt_w;
                     count_in   = count_ff + CNT_W'(1);
                  end
               end
               OP_READ: begin
                  if (pos_w >= cnt_w) begin
                     status_in = ST_BAD_POS;
                  end else begin
                     cmd.probe = PRB_SELECT;
                     tree_go   = 1'b1;
                  end
               end
               OP_INSERT: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else if (pos_w > cnt_w) begin
                     status_in = ST_BAD_POS;
                  end else begin
                     cmd.action = ACT_INSERT;
                     count_in   = count_ff + CNT_W'(1);
                  end
               end
               OP_DELETE: begin
                  if (pos_w >= cnt_w) begin
                     status_in = ST_BAD_POS;
                  end else begin
                     cmd.action = ACT_DELETE;
                     count_in   = count_ff - CNT_W'(1);
                  end
               end
               OP_SEARCH: begin
                  cmd.probe = PRB_MATCH;
                  tree_go   = 1'b1;
               end
               default: status_in = ST_OK;
            endcase
         end
         S_TREE: begin
            wait_in = wait_ff - WAIT_W'(1);
         end
         S_EMIT: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
            if (op_ff == OP_READ && status_ff == ST_OK) begin
               rsp_read_in = root.data;
            end else if (op_ff == OP_SEARCH) begin
               if (root.hit) begin
                  rsp_status_in = ST_OK;
                  rsp_found_in  = FOUND_W'(root.index);
               end else begin
                  rsp_status_in = ST_NO_KEY;
               end
            end
         end
         default: req_chan.ready = 1'b0;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   assign cells_idle   = (cmd.action == ACT_HOLD) && (cmd.probe == PRB_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_chan.op);
         pos_ff <= req_chan.position;
         val_ff <= req_chan.value;
      end
      status_ff <= status_in;
      wait_ff   <= wait_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_read_ff   <= rsp_read_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.read_value  = rsp_read_ff;
   assign rsp_chan.found_index = rsp_found_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   `PLIL_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `PLIL_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == S_EXEC)
   `PLIL_ASSERT_ALWAYS(a_cells_hold, clock, reset, (state_ff == S_EXEC) || cells_idle)

endmodule

[tb/plil_list_check.sv]
// ----------------------------------------------------------------------------
// Positional list response checker
// Watches the request and response channels of the list. Keeps its own copy
// of the entries and the count, works out the response of every accepted
// request and compares each response transfer, field by field, with the
// oldest one still due. Hands the failure and pending counts to the top.
// ----------------------------------------------------------------------------
module plil_list_check (
   input  logic  clock,
   input  logic  reset,
   plil_req_if   req,
   plil_rsp_if   rsp,
   output int    fail_count,
   output int    pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import plil_pkg::*;

   typedef struct packed {
      status_type               status;
      logic signed [VAL_W-1:0]  read_value;
      logic [FOUND_W-1:0]       found_index;
      logic [ECNT_W-1:0]        entry_count;
   } list_rsp_type;

   logic signed [VAL_W-1:0]  list_mem [CAPACITY];
   int unsigned              list_len = 0;
   list_rsp_type             rsp_due [$];
   int                       errs = 0;

   function automatic list_rsp_type apply_list_op(input logic [OP_W-1:0] op,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic signed [VAL_W-1:0] val);
      list_rsp_type r;
      logic         hit;
      r.status      = ST_OK;
      r.read_value  = '0;
      r.found_index = '0;
      hit           = 1'b0;
      case (op)
         OP_CLEAR: begin
            list_len = 0;
         end
         OP_APPEND: begin
            if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               list_mem[list_len] = val;
               list_len++;
            end
         end
         OP_READ: begin
            if (pos >= list_len) begin
               r.status = ST_BAD_POS;
            end else begin
               r.read_value = list_mem[pos];
            end
         end
         OP_INSERT: begin
            if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (pos > list_len) begin
               r.status = ST_BAD_POS;
            end else begin
               for (int i = list_len; i > pos; i--) begin
                  list_mem[i] = list_mem[i-1];
               end
               list_mem[pos] = val;
               list_len++;
            end
         end
         OP_DELETE: begin
            if (pos >= list_len) begin
               r.status = ST_BAD_POS;
            end else begin
               for (int i = pos; i + 1 < list_len; i++) begin
                  list_mem[i] = list_mem[i+1];
               end
               list_len--;
            end
         end
         OP_SEARCH: begin
            r.status = ST_NO_KEY;
            for (int i = 0; i < list_len; i++) begin
               if (!hit && list_mem[i] == val) begin
                  hit           = 1'b1;
                  r.status      = ST_OK;
                  r.found_index = i[FOUND_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
      r.entry_count = list_len[ECNT_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      list_rsp_type due;
      if (reset) begin
         rsp_due.delete();
         list_len = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (rsp_due.size() == 0) begin
               $error("response transfer with no request waiting");
               errs++;
            end else begin
               due = rsp_due.pop_front();
               check_field("status", due.status, rsp.status);
               check_field("read_value", due.read_value, rsp.read_value);
               check_field("found_index", due.found_index, rsp.found_index);
               check_field("entry_count", due.entry_count, rsp.entry_count);
            end
         end
         if (req.valid && req.ready) begin
            rsp_due.push_back(apply_list_op(req.op, req.position, req.value));
         end
      end
      fail_count <= errs;
      pending    <= rsp_due.size();
   end

endmodule

[tb/positional_list_insert_delete_search_tb.sv]
// ----------------------------------------------------------------------------
// Positional list testbench
// Drives directed list operations, then segments of random operations that
// grow, shrink or mix the list, under three idling patterns and one long
// response hold-off. A separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_search_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import plil_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

   localparam int MODE_GROW   = 0;
   localparam int MODE_SHRINK = 1;
   localparam int MODE_MIX    = 2;

   localparam int RANDOM_ITEMS = 1600;

   logic         clock;
   logic         reset;
   int           fail_count;
   int           pending_rsps;
   int           send_idle;
   int           recv_idle;
   logic         pressure_on;
   int unsigned  len_est;

   plil_req_if req_chan ();
   plil_rsp_if rsp_chan ();

   positional_list_insert_delete_search uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   plil_list_check list_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending_rsps)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5ms;
      $display("positional_list_insert_delete_search_tb NOT OK");
      $finish;
   end

   function automatic logic signed [VAL_W-1:0] pick_value();
      int unsigned r;
      int          k;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      if (r < 40) return k - 4;
      if (r < 50) return r[0] ? 32'h7fff_ffff : 32'h8000_0000;
      return $urandom;
   endfunction

   function automatic logic [POS_W-1:0] pick_pos(input int unsigned hi);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return POS_W'($urandom_range(0, hi));
      if (r < 80) return POS_W'(hi + 1);
      return POS_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [OP_W-1:0] pick_op(input int mode);
      int unsigned r;
      int unsigned ta, tb, tc, td, te, tf;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_GROW: begin
            ta = 45; tb = 80; tc = 86; td = 90; te = 97; tf = 98;
         end
         MODE_SHRINK: begin
            ta = 10; tb = 20; tc = 35; td = 80; te = 95; tf = 98;
         end
         default: begin
            ta = 20; tb = 40; tc = 60; td = 75; te = 95; tf = 98;
         end
      endcase
      if (r < ta) return OP_APPEND;
      if (r < tb) return OP_INSERT;
      if (r < tc) return OP_READ;
      if (r < td) return OP_DELETE;
      if (r < te) return OP_SEARCH;
      if (r < tf) return OP_CLEAR;
      return r[0] ? OP_UNUSED_A : OP_UNUSED_B;
   endfunction

   // offer one request, idling first at the current sender rate; track list length
   task automatic push_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] val);
      if ($urandom_range(0, 99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.op       <= op;
      req_chan.position <= pos;
      req_chan.value    <= val;
      do @(posedge clock); while (!req_chan.ready);
      case (op)
         OP_CLEAR:  len_est = 0;
         OP_APPEND: if (len_est < CAPACITY) len_est++;
         OP_INSERT: if (len_est < CAPACITY && pos <= len_est) len_est++;
         OP_DELETE: if (pos < len_est) len_est--;
         default: begin
         end
      endcase
   endtask

   initial begin
      int unsigned        r;
      int                 mode;
      logic [OP_W-1:0]    op;
      logic [POS_W-1:0]   pos;
      req_chan.valid    <= 1'b0;
      req_chan.op       <= '0;
      req_chan.position <= '0;
      req_chan.value    <= '0;
      send_idle   = 27;
      recv_idle   = 75;
      pressure_on = 1'b0;
      len_est     = 0;
      mode        = MODE_MIX;
      do @(posedge clock); while (reset);

      push_item(OP_READ, 8'd0, 32'sd0);
      push_item(OP_DELETE, 8'd0, 32'sd0);
      push_item(OP_SEARCH, 8'd0, 32'sd0);
      push_item(OP_INSERT, 8'd1, 32'sd9);
      push_item(OP_APPEND, 8'd0, 32'h7fff_ffff);
      push_item(OP_APPEND, 8'd0, 32'h8000_0000);
      push_item(OP_INSERT, 8'd0, -32'sd1);
      push_item(OP_INSERT, 8'd3, 32'sd0);
      push_item(OP_INSERT, 8'd5, 32'sd7);
      push_item(OP_READ, 8'd0, 32'sd0);
      push_item(OP_READ, 8'd3, 32'sd0);
      push_item(OP_READ, 8'd4, 32'sd0);
      push_item(OP_READ, 8'd255, 32'sd0);
      push_item(OP_SEARCH, 8'd0, 32'h8000_0000);
      push_item(OP_APPEND, 8'd0, 32'sd5);
      push_item(OP_INSERT, 8'd1, 32'sd5);
      push_item(OP_SEARCH, 8'd0, 32'sd5);
      push_item(OP_UNUSED_A, 8'd255, 32'hffff_ffff);
      push_item(OP_UNUSED_B, 8'd0, 32'sd0);
      push_item(OP_DELETE, 8'd255, 32'sd0);
      push_item(OP_DELETE, 8'd5, 32'sd0);
      push_item(OP_DELETE, 8'd0, 32'sd0);
      push_item(OP_CLEAR, 8'd0, 32'sd0);
      push_item(OP_READ, 8'd0, 32'sd0);
      push_item(OP_SEARCH, 8'd0, -32'sd1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle = 75;
            recv_idle = 27;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle   = 0;
            recv_idle   = 0;
            pressure_on = 1'b1;
         end
         if (n % 100 == 0) begin
            r    = $urandom_range(0, 99);
            mode = (r < 45) ? MODE_GROW : (r < 65) ? MODE_SHRINK : MODE_MIX;
         end
         op = pick_op(mode);
         case (op) inside
            OP_READ, OP_DELETE: pos = pick_pos((len_est == 0) ? 0 : len_est - 1);
            OP_INSERT:          pos = pick_pos(len_est);
            default:            pos = POS_W'($urandom_range(0, 255));
         endcase
         push_item(op, pos, pick_value());
      end
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsps != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0 && pending_rsps == 0) begin
         $display("positional_list_insert_delete_search_tb OK");
      end else begin
         $display("positional_list_insert_delete_search_tb NOT OK");
      end
      $finish;
   end

   // response side: random stalls, plus one long hold-off once pressure starts
   initial begin
      int   hold_left;
      logic hold_done;
      rsp_chan.ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_on && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/plil_pkg.sv
rtl/core/plil_if.sv
rtl/core/plil_cell.sv
rtl/core/plil_tree.sv
rtl/core/positional_list_insert_delete_search.sv
tb/plil_list_check.sv
tb/positional_list_insert_delete_search_tb.sv
